// ===== sv/cidrp_pkg.sv =====
// ----------------------------------------------------------------------------
// cidrp_pkg
// Shared types and character constants for the IPv4 CIDR text parser.
// ----------------------------------------------------------------------------
package cidrp_pkg;

   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam int AddrWidth   = 32;
   localparam int PrefixWidth = 7;

   typedef enum logic [2:0] {
      PHASE_OCT0   = 3'd0,
      PHASE_OCT1   = 3'd1,
      PHASE_OCT2   = 3'd2,
      PHASE_OCT3   = 3'd3,
      PHASE_PREFIX = 3'd4,
      PHASE_DONE   = 3'd5,
      PHASE_ERROR  = 3'd7
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic [1:0]       oct_cnt;
      logic [9:0]       oct_acc;
      logic [23:0]      finished;
      logic [6:0]       pfx_acc;
      logic [1:0]       pfx_cnt;
   } parse_state_type;

   typedef struct packed {
      logic [AddrWidth-1:0]   address;
      logic [PrefixWidth-1:0] prefix_length;
      logic                   parse_ok;
   } parse_result_type;

   localparam parse_state_type STATE_RESET = '{
      phase:    PHASE_OCT0,
      oct_cnt:  2'd0,
      oct_acc:  10'd0,
      finished: 24'd0,
      pfx_acc:  7'd0,
      pfx_cnt:  2'd0
   };

endpackage

// ===== sv/cidrp_parse.sv =====
// ----------------------------------------------------------------------------
// cidrp_parse
// Parse state register and the one-character update of octets and prefix.
// ----------------------------------------------------------------------------
module cidrp_parse (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_valid,
   input  logic [7:0]                  step_char,
   input  logic                        step_last,
   output cidrp_pkg::parse_result_type step_result
);
   import cidrp_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type upd;
   logic            is_digit;
   logic            is_sep;
   logic [3:0]      digit_val;
   logic [13:0]     oct_times10;
   logic [10:0]     pfx_times10;
   logic [1:0]      pfx_cnt_inc;

   always_comb begin
      is_digit    = (step_char >= CHAR_ZERO) && (step_char <= CHAR_NINE);
      is_sep      = (step_char == CHAR_DOT) || (step_char == CHAR_SLASH);
      digit_val   = 4'(step_char - CHAR_ZERO);
      oct_times10 = {1'b0, state_ff.oct_acc, 3'b000} + {3'b000, state_ff.oct_acc, 1'b0}
                    + {10'd0, digit_val};
      pfx_times10 = {1'b0, state_ff.pfx_acc, 3'b000} + {3'b000, state_ff.pfx_acc, 1'b0}
                    + {7'd0, digit_val};
      pfx_cnt_inc = state_ff.pfx_cnt + 2'd1;

      upd = state_ff;
      unique case (state_ff.phase)
         PHASE_OCT0, PHASE_OCT1, PHASE_OCT2, PHASE_OCT3: begin
            if (is_sep) begin
               // The fourth octet stays in the accumulator for the address.
               if (state_ff.phase != PHASE_OCT3) begin
                  upd.finished = {state_ff.finished[15:0], state_ff.oct_acc[7:0]};
                  upd.oct_acc  = 10'd0;
               end else begin
                  upd.oct_acc  = {2'b00, state_ff.oct_acc[7:0]};
               end
               upd.oct_cnt = 2'd0;
               upd.phase   = phase_type'(state_ff.phase + 3'd1);
            end else if (!is_digit || state_ff.oct_cnt == 2'd3) begin
               upd.phase = PHASE_ERROR;
            end else begin
               upd.oct_acc = oct_times10[9:0];
               upd.oct_cnt = state_ff.oct_cnt + 2'd1;
            end
         end
         PHASE_PREFIX: begin
            if (!is_digit) begin
               upd.phase = PHASE_ERROR;
            end else begin
               upd.pfx_acc = pfx_times10[6:0];
               upd.pfx_cnt = pfx_cnt_inc;
               if (pfx_cnt_inc >= 2'd2) begin
                  upd.phase = PHASE_DONE;
               end
            end
         end
         default: begin
            upd = state_ff;
         end
      endcase

      step_result.parse_ok = (upd.phase == PHASE_DONE) ||
                             (upd.phase == PHASE_PREFIX && upd.pfx_cnt != 2'd0);
      if (step_result.parse_ok) begin
         step_result.address       = {upd.finished, upd.oct_acc[7:0]};
         step_result.prefix_length = upd.pfx_acc;
      end else begin
         step_result.address       = '0;
         step_result.prefix_length = '0;
      end

      if (!step_valid) begin
         state_in = state_ff;
      end else if (step_last) begin
         state_in = STATE_RESET;
      end else begin
         state_in = upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/ipv4_cidr_text_parser_core.sv =====
// ----------------------------------------------------------------------------
// ipv4_cidr_text_parser_core
// Parses a.b.c.d/m text, one character per item, into address and prefix.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries one character per item in string order,
// with req_tlast on the final character. For each string one item leaves on
// the rsp_ channel: the address and prefix length in rsp_tdata and the
// parse-ok flag in rsp_tuser; a failed parse gives zero address and prefix.
// Characters other than the last produce no output item.
// A character is registered in the input register and is folded into the
// parse state when it leaves it; a last character also loads the result
// of its string into the output register, from which it is shown on rsp_.
// Throughput: one character per cycle while no last character waits on a
// stalled output; the parse update is a single short multiply-by-ten and add.
// Reset clears the input and output valid flags and returns the parser to the
// start of a string. When the receiver stalls, the result holds in the output
// register, characters without req_tlast keep flowing through the parser, and
// only a new last character waits in the input register, with req_tready low,
// until the output frees.
// ----------------------------------------------------------------------------
module ipv4_cidr_text_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_char
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] address, [38:32] prefix_length, [39] zero
   output logic [0:0]  rsp_tuser    // [0] parse_ok
);
   import cidrp_pkg::*;

   logic             in_valid_ff;
   logic             in_valid_in;
   logic [7:0]       in_char_ff;
   logic             in_last_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   parse_result_type rsp_result_ff;
   parse_result_type step_result;
   logic             advance;
   logic             load_rsp;

   always_comb begin
      advance      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
      load_rsp     = advance && in_last_ff;
      req_tready   = !in_valid_ff || advance;
      in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_tready);
   end

   cidrp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (advance),
      .step_char   (in_char_ff),
      .step_last   (in_last_ff),
      .step_result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_char_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (load_rsp) begin
         rsp_result_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_result_ff.prefix_length, rsp_result_ff.address};
   assign rsp_tuser  = rsp_result_ff.parse_ok;

`ifndef ASSERT_OFF
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_result_ff.parse_ok |->
         rsp_result_ff.address == '0 && rsp_result_ff.prefix_length == '0)
      else $error("failed parse carries a nonzero address or prefix");

   a_prefix_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_result_ff.prefix_length <= 7'd99)
      else $error("prefix length above 99");

   a_last_loads: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff)
      else $error("last character did not produce a result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !load_rsp)
      else $error("result register overwritten while stalled");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_char_ff) && $stable(in_last_ff))
      else $error("held character lost from input register");
`endif

endmodule

// ===== sim/tb_ipv4_cidr_text_parser_core.sv =====
// ----------------------------------------------------------------------------
// tb_ipv4_cidr_text_parser_core
// Self-checking bench for the a.b.c.d/m text parser.
// ----------------------------------------------------------------------------
// Strings are fed one character per item on the req_ stream. A software copy
// of the parser follows every accepted character and queues the result that
// each last character must produce. Results leaving on the rsp_ stream are
// checked field by field against that queue. A short directed set covers
// the corner cases, and then mostly well-formed address strings with random
// content follow, mixed with corrupted strings and plain noise. Both sides
// pause at random, and once the receiver holds off long enough to stall the
// input.
// ----------------------------------------------------------------------------
module tb_ipv4_cidr_text_parser_core;
   timeunit 1ns;
   timeprecision 1ps;

   import cidrp_pkg::*;

   localparam int RandomItems = 1150;
   localparam int LongHold    = 300;

   class cidr_result_tracker;
      phase_type        phase;
      logic [1:0]       octet_digits;
      logic [9:0]       octet_value;
      logic [23:0]      upper_octets;
      logic [6:0]       prefix_value;
      logic [1:0]       prefix_digits;
      parse_result_type pending_results[$];
      int               mismatches;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         phase         = PHASE_OCT0;
         octet_digits  = '0;
         octet_value   = '0;
         upper_octets  = '0;
         prefix_value  = '0;
         prefix_digits = '0;
      endfunction

      function void take_char(logic [7:0] c, logic last);
         parse_result_type res;
         logic             digit;
         digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
         case (phase)
            PHASE_OCT0, PHASE_OCT1, PHASE_OCT2, PHASE_OCT3: begin
               if (c == CHAR_DOT || c == CHAR_SLASH) begin
                  // The fourth octet stays in the accumulator, truncated to a byte.
                  if (phase == PHASE_OCT3) begin
                     octet_value = {2'b00, octet_value[7:0]};
                  end else begin
                     upper_octets = {upper_octets[15:0], octet_value[7:0]};
                     octet_value  = '0;
                  end
                  octet_digits = '0;
                  phase = phase_type'(phase + 3'd1);
               end else if (!digit || octet_digits == 2'd3) begin
                  phase = PHASE_ERROR;
               end else begin
                  octet_value  = 10'(octet_value * 10 + (c - CHAR_ZERO));
                  octet_digits = octet_digits + 2'd1;
               end
            end
            PHASE_PREFIX: begin
               if (!digit) begin
                  phase = PHASE_ERROR;
               end else begin
                  prefix_value  = 7'(prefix_value * 10 + (c - CHAR_ZERO));
                  prefix_digits = prefix_digits + 2'd1;
                  if (prefix_digits == 2'd2) begin
                     phase = PHASE_DONE;
                  end
               end
            end
            default: ;
         endcase
         if (last) begin
            if (phase == PHASE_DONE || (phase == PHASE_PREFIX && prefix_digits != 2'd0)) begin
               res.address       = {upper_octets, octet_value[7:0]};
               res.prefix_length = prefix_value;
               res.parse_ok      = 1'b1;
            end else begin
               res = '0;
            end
            pending_results.push_back(res);
            restart();
         end
      endfunction

      function void check_result(logic [39:0] data, logic [0:0] flag);
         parse_result_type exp;
         if (pending_results.size() == 0) begin
            $error("result arrived with none expected: tdata %h, tuser %h", data, flag);
            mismatches++;
            return;
         end
         exp = pending_results.pop_front();
         if (data[31:0] !== exp.address) begin
            $error("address: expected %h, actual %h", exp.address, data[31:0]);
            mismatches++;
         end
         if (data[38:32] !== exp.prefix_length) begin
            $error("prefix_length: expected %0d, actual %0d", exp.prefix_length, data[38:32]);
            mismatches++;
         end
         if (flag[0] !== exp.parse_ok) begin
            $error("parse_ok: expected %b, actual %b", exp.parse_ok, flag[0]);
            mismatches++;
         end
         if (data[39] !== 1'b0) begin
            $error("tdata pad bit: expected 0, actual %b", data[39]);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   cidr_result_tracker tracker;
   logic [7:0]         line_chars[$];
   int                 chars_sent   = 0;
   int                 results_seen = 0;

   ipv4_cidr_text_parser_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #1_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] dig(int n);
      return CHAR_ZERO + 8'(n);
   endfunction

   // Sends line_chars as one string, the last character flagged with tlast.
   task automatic send_line();
      int gap;
      bit burst;
      burst = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < line_chars.size(); i++) begin
         req_tvalid <= 1'b1;
         req_tdata  <= line_chars[i];
         req_tlast  <= (i == line_chars.size() - 1);
         do @(posedge clock); while (!req_tready);
         tracker.take_char(line_chars[i], i == line_chars.size() - 1);
         chars_sent++;
         @(negedge clock);
         gap = burst ? 0 : pick_gap();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic make_address_line();
      int n;
      line_chars.delete();
      for (int k = 0; k < 4; k++) begin
         n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
         repeat (n) line_chars.push_back(dig($urandom_range(0, 9)));
         line_chars.push_back($urandom_range(0, 1) ? CHAR_DOT : CHAR_SLASH);
      end
      n = $urandom_range(0, 19);
      n = (n == 0) ? 0 : (n < 5) ? 1 : 2;
      repeat (n) line_chars.push_back(dig($urandom_range(0, 9)));
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) line_chars.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   // Corrupts one position: a random byte, an extra digit, or a cut.
   task automatic break_line();
      int pos;
      pos = $urandom_range(0, line_chars.size() - 1);
      case ($urandom_range(0, 2))
         0: line_chars[pos] = 8'($urandom_range(0, 255));
         1: line_chars.insert(pos, dig($urandom_range(0, 9)));
         default: begin
            while (line_chars.size() > pos + 1) void'(line_chars.pop_back());
         end
      endcase
   endtask

   task automatic make_noise_line();
      int r;
      line_chars.delete();
      repeat ($urandom_range(1, 8)) begin
         r = $urandom_range(0, 3);
         if (r < 2) begin
            line_chars.push_back(8'($urandom_range(0, 255)));
         end else if (r == 2) begin
            line_chars.push_back(dig($urandom_range(0, 9)));
         end else begin
            line_chars.push_back($urandom_range(0, 1) ? CHAR_DOT : CHAR_SLASH);
         end
      end
   endtask

   // Result checking on the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_result(rsp_tdata, rsp_tuser);
         results_seen++;
      end
   end

   // Receiver pacing, including one long hold-off once traffic is flowing.
   initial begin
      int  stall_left;
      bit  steady;
      bit  long_hold_due;
      stall_left    = 0;
      steady        = 0;
      long_hold_due = 1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 199) == 0) begin
            steady = !steady;
         end
         if (stall_left == 0) begin
            if (long_hold_due && results_seen >= 20) begin
               long_hold_due = 0;
               stall_left    = LongHold;
            end else if (!steady && $urandom_range(0, 99) < 25) begin
               stall_left = pick_gap();
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
         @(negedge clock);
      end
   end

   initial begin
      int r;
      tracker = new();
      @(negedge clock);
      while (reset) @(negedge clock);

      // Empty octets, two prefix digits, then a trailing byte that is ignored.
      line_chars = '{CHAR_DOT, CHAR_DOT, CHAR_DOT, CHAR_DOT, dig(9), dig(9), 8'hFF};
      send_line();
      // A fourth digit in the first octet; the rest of the string is ignored.
      line_chars = '{dig(1), dig(2), dig(3), dig(4), dig(5)};
      send_line();
      // A stray byte in an octet, also as a one-character string.
      line_chars = '{8'h00};
      send_line();
      // The string ends before any prefix digit.
      line_chars = '{dig(2), CHAR_SLASH};
      send_line();
      // A single prefix digit.
      line_chars = '{CHAR_SLASH, CHAR_SLASH, CHAR_SLASH, CHAR_SLASH, dig(7)};
      send_line();
      // A non-digit where the prefix should begin.
      line_chars = '{CHAR_DOT, CHAR_DOT, CHAR_DOT, CHAR_DOT, 8'h41};
      send_line();

      while (chars_sent < RandomItems) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            make_address_line();
         end else if (r < 85) begin
            make_address_line();
            break_line();
         end else begin
            make_noise_line();
         end
         send_line();
      end
      req_tvalid <= 1'b0;

      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
